FILE: rtl/core/tgd_pkg.sv
// ----------------------------------------------------------------------------
// tgd_pkg: shared types and constants of the touch gesture detector
// gesture codes, register indexes, reset values and the press flag bundle
// ----------------------------------------------------------------------------
package tgd_pkg;

  // default widths
  localparam int COORD_BITS_DEF = 11;
  localparam int TIME_BITS_DEF  = 32;

  // fixed widths of the register port
  localparam int HOLD_BITS = 16;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_RADIUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLIDE_VERT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLIDE_HORZ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_EDGE  = 3'd5;

  // register reset values
  localparam int TAP_RADIUS_RST  = 40;
  localparam int SLIDE_VERT_RST  = 40;
  localparam int SLIDE_HORZ_RST  = 100;
  localparam int HOLD_TIME_RST   = 400;
  localparam int TOP_EDGE_RST    = 31;
  localparam int BOTTOM_EDGE_RST = 1057;

  // gesture codes
  typedef enum logic [3:0] {
    G_NONE      = 4'd0,
    G_DOWN      = 4'd1,
    G_UP        = 4'd2,
    G_DOUBLE    = 4'd3,
    G_HOLD      = 4'd4,
    G_SL_UP     = 4'd5,
    G_SL_DOWN   = 4'd6,
    G_SL_LEFT   = 4'd7,
    G_SL_RIGHT  = 4'd8,
    G_TWO_RIGHT = 4'd9
  } gesture_e;

  // per-press control flags
  typedef struct packed {
    logic       pressed;
    logic       anchor_saved;
    logic       slid;
    logic       hold_reported;
    logic       timer_armed;
    logic       vertical_zeroed;
    logic [1:0] tap_count;
  } flags_t;

endpackage

FILE: rtl/core/tgd_eval.sv
// ----------------------------------------------------------------------------
// tgd_eval: gesture evaluation for one touch sample
// release, press start, slide and hold tests; gives the next tracker state
// ----------------------------------------------------------------------------
module tgd_eval #(
  parameter int COORD_BITS = tgd_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = tgd_pkg::TIME_BITS_DEF
) (
  // settings
  input  logic [COORD_BITS-1:0]         tap_radius_i,
  input  logic [COORD_BITS-1:0]         slide_vertical_min_i,
  input  logic [COORD_BITS-1:0]         slide_horizontal_min_i,
  input  logic [tgd_pkg::HOLD_BITS-1:0] hold_time_i,
  input  logic [COORD_BITS-1:0]         top_edge_i,
  input  logic [COORD_BITS-1:0]         bottom_edge_i,
  // current state
  input  tgd_pkg::flags_t               flags_i,
  input  logic [COORD_BITS-1:0]         anchor_x_i,
  input  logic [COORD_BITS-1:0]         anchor_y_i,
  input  logic [COORD_BITS-1:0]         last_x_i,
  input  logic [COORD_BITS-1:0]         last_y_i,
  input  logic [TIME_BITS-1:0]          press_start_i,
  input  tgd_pkg::gesture_e             gesture_i,
  // sample
  input  logic [3:0]                    contact_count_i,
  input  logic [COORD_BITS-1:0]         first_x_i,
  input  logic [COORD_BITS-1:0]         first_y_i,
  input  logic [COORD_BITS-1:0]         second_x_i,
  input  logic [TIME_BITS-1:0]          time_now_i,
  // next state
  output tgd_pkg::flags_t               flags_o,
  output logic [COORD_BITS-1:0]         anchor_x_o,
  output logic [COORD_BITS-1:0]         anchor_y_o,
  output logic [COORD_BITS-1:0]         last_x_o,
  output logic [COORD_BITS-1:0]         last_y_o,
  output logic [TIME_BITS-1:0]          press_start_o,
  output tgd_pkg::gesture_e             gesture_o
);
  import tgd_pkg::*;

  // signed width that holds a coordinate plus or minus a distance
  localparam int CW = COORD_BITS + 2;

  function automatic logic signed [CW-1:0] ext(input logic [COORD_BITS-1:0] v);
    return signed'({2'b00, v});
  endfunction

  // strictly inside the square zone round the anchor
  function automatic logic in_zone(input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y,
                                   input logic signed [CW-1:0] ax,
                                   input logic signed [CW-1:0] ay,
                                   input logic signed [CW-1:0] r);
    return (x < ax + r) && (x > ax - r) && (y < ay + r) && (y > ay - r);
  endfunction

  flags_t                  fl;
  logic [COORD_BITS-1:0]   ax, ay;
  logic [TIME_BITS-1:0]    pst;
  gesture_e                g;
  logic signed [CW-1:0]    r_s, h_s, v_s, ax_s, ay_s, fx_s, fy_s, sx_s;
  logic                    slide_hit;
  logic [TIME_BITS-1:0]    elapsed;

  always_comb begin
    fl        = flags_i;
    ax        = anchor_x_i;
    ay        = anchor_y_i;
    pst       = press_start_i;
    g         = gesture_i;
    slide_hit = 1'b0;
    r_s       = ext(tap_radius_i);
    h_s       = ext(slide_horizontal_min_i);
    v_s       = flags_i.vertical_zeroed ? '0 : ext(slide_vertical_min_i);
    fx_s      = ext(first_x_i);
    fy_s      = ext(first_y_i);
    sx_s      = ext(second_x_i);

    // release ends the press
    if (flags_i.pressed && (contact_count_i == 4'd0)) begin
      fl.anchor_saved = 1'b0;
      fl.timer_armed  = 1'b0;
      if (!flags_i.slid && !flags_i.hold_reported) begin
        g = G_UP;
        if (in_zone(ext(last_x_i), ext(last_y_i), ext(anchor_x_i), ext(anchor_y_i), r_s))
        begin
          fl.tap_count = fl.tap_count + 2'd1;
        end
        if (fl.tap_count >= 2'd2) begin
          fl.tap_count = 2'd0;
          g            = G_DOUBLE;
        end
      end
      fl.slid            = 1'b0;
      fl.hold_reported   = 1'b0;
      fl.vertical_zeroed = 1'b0;
    end

    if (contact_count_i != 4'd0) begin
      fl.pressed = 1'b1;

      // press start: move the anchor on each axis where the touch lies outside the old tap zone, arm the timer
      if (!fl.anchor_saved) begin
        if ((fx_s > ext(ax) + r_s) || (fx_s < ext(ax) - r_s)) begin
          ax           = first_x_i;
          fl.tap_count = 2'd0;
        end
        if ((fy_s > ext(ay) + r_s) || (fy_s < ext(ay) - r_s)) begin
          ay           = first_y_i;
          fl.tap_count = 2'd0;
        end
        pst             = time_now_i;
        fl.timer_armed  = 1'b1;
        fl.anchor_saved = 1'b1;
        g               = G_DOWN;
      end

      ax_s = ext(ax);
      ay_s = ext(ay);

      // slide tests, first match wins
      if (contact_count_i == 4'd1) begin
        if ((fy_s < ay_s - v_s) || (ay > bottom_edge_i)) begin
          fl.vertical_zeroed = 1'b1;
          slide_hit          = 1'b1;
          g                  = G_SL_UP;
        end else if ((fy_s > ay_s + v_s) || (ay < top_edge_i)) begin
          fl.vertical_zeroed = 1'b1;
          slide_hit          = 1'b1;
          g                  = G_SL_DOWN;
        end else if (fx_s < ax_s - h_s) begin
          slide_hit = 1'b1;
          g         = G_SL_LEFT;
        end else if (fx_s > ax_s + h_s) begin
          slide_hit = 1'b1;
          g         = G_SL_RIGHT;
        end
      end else if ((contact_count_i == 4'd2) && (fx_s > ax_s + h_s) &&
                   (sx_s > ax_s + h_s)) begin
        slide_hit = 1'b1;
        g         = G_TWO_RIGHT;
      end

      // hold once per press after the timeout
      elapsed = time_now_i - pst;
      if (slide_hit) begin
        fl.slid = 1'b1;
      end else if (!fl.slid && fl.timer_armed && (elapsed > TIME_BITS'(hold_time_i)) &&
                   in_zone(fx_s, fy_s, ax_s, ay_s, r_s) && !fl.hold_reported) begin
        fl.hold_reported = 1'b1;
        g                = G_HOLD;
      end
    end else begin
      ax_s       = ext(ax);
      ay_s       = ext(ay);
      elapsed    = '0;
      fl.pressed = 1'b0;
    end
  end

  assign flags_o       = fl;
  assign anchor_x_o    = ax;
  assign anchor_y_o    = ay;
  assign last_x_o      = (contact_count_i != 4'd0) ? first_x_i : last_x_i;
  assign last_y_o      = (contact_count_i != 4'd0) ? first_y_i : last_y_i;
  assign press_start_o = pst;
  assign gesture_o     = g;

endmodule

FILE: rtl/core/touch_gesture_detector.sv
// ----------------------------------------------------------------------------
// touch_gesture_detector: gesture recognizer for touch panel samples
// Each input word is one panel sample (contact count, first contact x/y,
// second contact x, millisecond timestamp). Each sample gives one output
// word: the latched gesture code (none, down, up, double tap, hold, slide
// up/down/left/right, two-finger slide right).
// Channels: input and output use valid/ready; settings are written on a
// plain write port (enable, index, data), by the user only while the block
// is idle (not enforced); an index beyond the register list is ignored.
// Path: a sample is staged in the input register, is evaluated and its
// result word is registered in the output register, where it stands
// until the receiver takes it.
// Throughput: one sample per cycle unless the output stalls; the evaluation
// is a single pass of compare and add logic between the two registers.
// Stall: while the output word waits, the input register still takes one
// more word; then ready drops until the receiver takes the result.
// Reset: all tracker state clears (no press, anchor at the origin, gesture
// none) and the settings return to their defaults.
// ----------------------------------------------------------------------------
module touch_gesture_detector #(
  parameter int COORD_BITS = tgd_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = tgd_pkg::TIME_BITS_DEF,
  parameter int CFG_W      = (COORD_BITS > tgd_pkg::HOLD_BITS) ? COORD_BITS
                                                              : tgd_pkg::HOLD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // settings write port
  input  logic                          cfg_we_i,
  input  logic [tgd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_wdata_i,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    contact_count_i,
  input  logic [COORD_BITS-1:0]         first_x_i,
  input  logic [COORD_BITS-1:0]         first_y_i,
  input  logic [COORD_BITS-1:0]         second_x_i,
  input  logic [TIME_BITS-1:0]          time_now_i,
  // gesture output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0]                    gesture_o
);
  import tgd_pkg::*;

  // settings registers
  logic [COORD_BITS-1:0] tap_radius_q, slide_vert_q, slide_horz_q;
  logic [COORD_BITS-1:0] top_edge_q, bottom_edge_q;
  logic [HOLD_BITS-1:0]  hold_time_q;

  // input register
  logic                  s1_valid_q;
  logic [3:0]            s1_count_q;
  logic [COORD_BITS-1:0] s1_fx_q, s1_fy_q, s1_sx_q;
  logic [TIME_BITS-1:0]  s1_now_q;

  // tracker state, gesture_q doubles as the output register
  flags_t                flags_q, flags_d;
  logic [COORD_BITS-1:0] anchor_x_q, anchor_x_d, anchor_y_q, anchor_y_d;
  logic [COORD_BITS-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic [TIME_BITS-1:0]  press_start_q, press_start_d;
  gesture_e              gesture_q, gesture_d;
  logic                  out_valid_q;

  logic in_fire, advance, s1_fire;

  // handshake
  assign advance    = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // settings writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_radius_q  <= COORD_BITS'(TAP_RADIUS_RST);
      slide_vert_q  <= COORD_BITS'(SLIDE_VERT_RST);
      slide_horz_q  <= COORD_BITS'(SLIDE_HORZ_RST);
      hold_time_q   <= HOLD_BITS'(HOLD_TIME_RST);
      top_edge_q    <= COORD_BITS'(TOP_EDGE_RST);
      bottom_edge_q <= COORD_BITS'(BOTTOM_EDGE_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TAP_RADIUS:  tap_radius_q  <= cfg_wdata_i[COORD_BITS-1:0];
        REG_SLIDE_VERT:  slide_vert_q  <= cfg_wdata_i[COORD_BITS-1:0];
        REG_SLIDE_HORZ:  slide_horz_q  <= cfg_wdata_i[COORD_BITS-1:0];
        REG_HOLD_TIME:   hold_time_q   <= cfg_wdata_i[HOLD_BITS-1:0];
        REG_TOP_EDGE:    top_edge_q    <= cfg_wdata_i[COORD_BITS-1:0];
        REG_BOTTOM_EDGE: bottom_edge_q <= cfg_wdata_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_count_q <= contact_count_i;
      s1_fx_q    <= first_x_i;
      s1_fy_q    <= first_y_i;
      s1_sx_q    <= second_x_i;
      s1_now_q   <= time_now_i;
    end
  end

  // evaluation of the staged sample
  tgd_eval #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_eval (
    .tap_radius_i           (tap_radius_q),
    .slide_vertical_min_i   (slide_vert_q),
    .slide_horizontal_min_i (slide_horz_q),
    .hold_time_i            (hold_time_q),
    .top_edge_i             (top_edge_q),
    .bottom_edge_i          (bottom_edge_q),
    .flags_i                (flags_q),
    .anchor_x_i             (anchor_x_q),
    .anchor_y_i             (anchor_y_q),
    .last_x_i               (last_x_q),
    .last_y_i               (last_y_q),
    .press_start_i          (press_start_q),
    .gesture_i              (gesture_q),
    .contact_count_i        (s1_count_q),
    .first_x_i              (s1_fx_q),
    .first_y_i              (s1_fy_q),
    .second_x_i             (s1_sx_q),
    .time_now_i             (s1_now_q),
    .flags_o                (flags_d),
    .anchor_x_o             (anchor_x_d),
    .anchor_y_o             (anchor_y_d),
    .last_x_o               (last_x_d),
    .last_y_o               (last_y_d),
    .press_start_o          (press_start_d),
    .gesture_o              (gesture_d)
  );

  // tracker state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q       <= '0;
      anchor_x_q    <= '0;
      anchor_y_q    <= '0;
      last_x_q      <= '0;
      last_y_q      <= '0;
      press_start_q <= '0;
      gesture_q     <= G_NONE;
    end else if (s1_fire) begin
      flags_q       <= flags_d;
      anchor_x_q    <= anchor_x_d;
      anchor_y_q    <= anchor_y_d;
      last_x_q      <= last_x_d;
      last_y_q      <= last_y_d;
      press_start_q <= press_start_d;
      gesture_q     <= gesture_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gesture_o   = gesture_q;

  // press and anchor flags move together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q.pressed == flags_q.anchor_saved) && (flags_q.timer_armed == flags_q.anchor_saved))
    else $error("press flags out of step");

  // a stored tap count never reaches two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.tap_count[1] == 1'b0)
    else $error("tap count not cleared on double tap");

  // outside a press the per-press flags are clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flags_q.pressed |-> (!flags_q.slid && !flags_q.hold_reported && !flags_q.vertical_zeroed))
    else $error("per-press flags left over after release");

  // a staged sample that moves on gives a result word next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_o)
    else $error("evaluated sample lost");

  // an empty input register always takes a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with empty input register");

endmodule

FILE: sim/gesture_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_checker: scoreboard for the touch gesture detector
// Watches the settings port and both valid/ready channels, tracks its own
// copy of the press state and settings, predicts the gesture word for each
// accepted sample and compares it with the oldest pending prediction when a
// result word is taken.
// ----------------------------------------------------------------------------
module gesture_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tgd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tgd_pkg::HOLD_BITS-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [3:0]                    contact_count_i,
  input  logic [10:0]                   first_x_i,
  input  logic [10:0]                   first_y_i,
  input  logic [10:0]                   second_x_i,
  input  logic [31:0]                   time_now_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [3:0]                    gesture_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  import tgd_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int TW = TIME_BITS_DEF;

  // settings copy
  logic [CW-1:0]        tap_radius;
  logic [CW-1:0]        slide_vert;
  logic [CW-1:0]        slide_horz;
  logic [HOLD_BITS-1:0] hold_ms;
  logic [CW-1:0]        top_edge;
  logic [CW-1:0]        bottom_edge;

  // press tracking state
  flags_t        fl;
  logic [CW-1:0] anchor_x;
  logic [CW-1:0] anchor_y;
  logic [CW-1:0] last_x;
  logic [CW-1:0] last_y;
  logic [TW-1:0] press_start;
  gesture_e      latched;

  gesture_e expected_gestures[$];
  int       fails;

  // strict square zone around the anchor, signed
  function automatic bit in_tap_zone(input int x, input int y);
    int r;
    int ax;
    int ay;
    r  = tap_radius;
    ax = anchor_x;
    ay = anchor_y;
    return (x < ax + r) && (x > ax - r) && (y < ay + r) && (y > ay - r);
  endfunction

  // sample with contacts: anchor on first touch, then slides, then hold
  function automatic gesture_e press_update(input logic [3:0] cnt, input int fx,
                                            input int fy, input int sx,
                                            input logic [TW-1:0] now);
    int            r;
    int            h;
    int            v;
    int            ax;
    int            ay;
    logic [TW-1:0] elapsed;
    r = tap_radius;
    h = slide_horz;
    v = 0;
    if (!fl.vertical_zeroed) begin
      v = slide_vert;
    end
    fl.pressed = 1'b1;
    last_x     = CW'(fx);
    last_y     = CW'(fy);

    if (!fl.anchor_saved) begin
      ax = anchor_x;
      ay = anchor_y;
      if (fx > ax + r || fx < ax - r) begin
        anchor_x     = CW'(fx);
        fl.tap_count = '0;
      end
      if (fy > ay + r || fy < ay - r) begin
        anchor_y     = CW'(fy);
        fl.tap_count = '0;
      end
      press_start     = now;
      fl.timer_armed  = 1'b1;
      fl.anchor_saved = 1'b1;
      latched         = G_DOWN;
    end

    ax = anchor_x;
    ay = anchor_y;
    // slide order: up, down, left, right, two-finger right
    if (cnt == 4'd1) begin
      if (fy < ay - v || ay > int'(bottom_edge)) begin
        fl.vertical_zeroed = 1'b1;
        fl.slid            = 1'b1;
        return G_SL_UP;
      end
      if (fy > ay + v || ay < int'(top_edge)) begin
        fl.vertical_zeroed = 1'b1;
        fl.slid            = 1'b1;
        return G_SL_DOWN;
      end
      if (fx < ax - h) begin
        fl.slid = 1'b1;
        return G_SL_LEFT;
      end
      if (fx > ax + h) begin
        fl.slid = 1'b1;
        return G_SL_RIGHT;
      end
    end else if (cnt == 4'd2 && fx > ax + h && sx > ax + h) begin
      fl.slid = 1'b1;
      return G_TWO_RIGHT;
    end

    // hold once per press, elapsed time wraps
    elapsed = now - press_start;
    if (!fl.slid && fl.timer_armed && elapsed > hold_ms && in_tap_zone(fx, fy) &&
        !fl.hold_reported) begin
      fl.hold_reported = 1'b1;
      return G_HOLD;
    end
    return latched;
  endfunction

  // one sample in, latched gesture out
  function automatic gesture_e track_sample(input logic [3:0] cnt, input logic [CW-1:0] fx,
                                            input logic [CW-1:0] fy, input logic [CW-1:0] sx,
                                            input logic [TW-1:0] now);
    // release ends the press, up or double tap unless slid or held
    if (fl.pressed && cnt == 4'd0) begin
      fl.anchor_saved = 1'b0;
      fl.timer_armed  = 1'b0;
      if (!fl.slid && !fl.hold_reported) begin
        latched = G_UP;
        if (in_tap_zone(last_x, last_y)) begin
          fl.tap_count = fl.tap_count + 2'd1;
        end
        if (fl.tap_count >= 2'd2) begin
          fl.tap_count = '0;
          latched      = G_DOUBLE;
        end
      end
      fl.slid            = 1'b0;
      fl.hold_reported   = 1'b0;
      fl.vertical_zeroed = 1'b0;
    end
    if (cnt > 4'd0) begin
      latched = press_update(cnt, fx, fy, sx, now);
    end else begin
      fl.pressed = 1'b0;
    end
    return latched;
  endfunction

  // settings writes, result compare, then prediction of the new sample
  always @(posedge clk_i or negedge rst_ni) begin
    gesture_e want;
    if (!rst_ni) begin
      tap_radius  = CW'(TAP_RADIUS_RST);
      slide_vert  = CW'(SLIDE_VERT_RST);
      slide_horz  = CW'(SLIDE_HORZ_RST);
      hold_ms     = HOLD_BITS'(HOLD_TIME_RST);
      top_edge    = CW'(TOP_EDGE_RST);
      bottom_edge = CW'(BOTTOM_EDGE_RST);
      fl          = '0;
      anchor_x    = '0;
      anchor_y    = '0;
      last_x      = '0;
      last_y      = '0;
      press_start = '0;
      latched     = G_NONE;
      fails       = 0;
      expected_gestures.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TAP_RADIUS:  tap_radius  = cfg_wdata_i[CW-1:0];
          REG_SLIDE_VERT:  slide_vert  = cfg_wdata_i[CW-1:0];
          REG_SLIDE_HORZ:  slide_horz  = cfg_wdata_i[CW-1:0];
          REG_HOLD_TIME:   hold_ms     = cfg_wdata_i;
          REG_TOP_EDGE:    top_edge    = cfg_wdata_i[CW-1:0];
          REG_BOTTOM_EDGE: bottom_edge = cfg_wdata_i[CW-1:0];
          // spare indexes write nothing
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_gestures.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: gesture word %0d with no sample pending", $time, gesture_i);
          end
        end else begin
          want = expected_gestures.pop_front();
          if (gesture_i !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: gesture mismatch, expected %0d got %0d", $time, want, gesture_i);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        expected_gestures.push_back(track_sample(contact_count_i, first_x_i, first_y_i,
                                                 second_x_i, time_now_i));
      end

      fail_count_o <= fails;
      pending_o    <= expected_gestures.size();
    end
  end

endmodule

FILE: sim/tb_touch_gesture_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_gesture_detector: testbench of the touch gesture detector
// Drives a directed list of touch sequences covering every gesture and the
// edge cases, then random press sequences and noise under several settings,
// with random gaps on both channels and one long output stall. A separate
// checker predicts and compares every gesture word.
// ----------------------------------------------------------------------------
module tb_touch_gesture_detector;

  import tgd_pkg::*;

  localparam int CW              = COORD_BITS_DEF;
  localparam int TW              = TIME_BITS_DEF;
  localparam int CFG_W           = HOLD_BITS;  // wider than the coordinates
  localparam int COORD_MAX       = (1 << CW) - 1;
  localparam int CLK_PERIOD      = 4;
  localparam int NUM_PHASES      = 5;
  localparam int WORDS_PER_PHASE = 140;
  localparam int LONG_STALL      = 300;
  localparam int CYCLE_LIMIT     = 200000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [3:0]           contact_count = '0;
  logic [CW-1:0]        first_x   = '0;
  logic [CW-1:0]        first_y   = '0;
  logic [CW-1:0]        second_x  = '0;
  logic [TW-1:0]        time_now  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [3:0]           gesture;

  int          fail_count;
  int          pending;
  int          words_sent  = 0;
  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;
  bit          long_stall  = 1'b0;
  int          base_x      = 500;
  int          base_y      = 500;
  logic [TW-1:0] ms_now    = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  touch_gesture_detector dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .contact_count_i (contact_count),
    .first_x_i       (first_x),
    .first_y_i       (first_y),
    .second_x_i      (second_x),
    .time_now_i      (time_now),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .gesture_o       (gesture)
  );

  gesture_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .contact_count_i (contact_count),
    .first_x_i       (first_x),
    .first_y_i       (first_y),
    .second_x_i      (second_x),
    .time_now_i      (time_now),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .gesture_i       (gesture),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // keep coordinates on the panel
  function automatic logic [CW-1:0] clip(input int v);
    logic [CW-1:0] c;
    if (v < 0) begin
      v = 0;
    end else if (v > COORD_MAX) begin
      v = COORD_MAX;
    end
    c = CW'(v);
    return c;
  endfunction

  // offer one sample word after a random gap, hold until taken
  task automatic send_sample(input logic [3:0] cnt, input logic [CW-1:0] fx,
                             input logic [CW-1:0] fy, input logic [CW-1:0] sx,
                             input logic [TW-1:0] now);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    contact_count <= cnt;
    first_x       <= fx;
    first_y       <= fy;
    second_x      <= sx;
    time_now      <= now;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // stop offering and let every pending gesture word come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int wait_cycles;
    int held;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_stall) begin
        out_ready <= 1'b0;
        for (held = 0; held < LONG_STALL; held++) @(posedge clk);
        long_stall = 1'b0;
      end
      wait_cycles = snk_idle_en ? $urandom_range(0, 12) : 0;
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // run limit
  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int                   phase;
    int                   phase_base;
    int                   moves;
    int                   span;
    int                   k;
    int                   px;
    int                   py;
    int                   settings [6];
    logic [3:0]           cnt;
    logic [TW-1:0]        t0;
    logic [CFG_W-1:0]     reg_val;
    logic [CFG_IDX_W-1:0] reg_idx [7];

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sequences with reset settings
    // release with no press changes nothing
    send_sample(4'd0, '1, '1, '1, '1);
    // tap then second tap in the zone gives double tap
    send_sample(4'd1, 11'd500, 11'd500, 11'd0, 32'd1000);
    send_sample(4'd0, 11'd500, 11'd500, 11'd0, 32'd1010);
    send_sample(4'd1, 11'd505, 11'd505, 11'd0, 32'd1020);
    send_sample(4'd0, 11'd505, 11'd505, 11'd0, 32'd1030);
    // many contacts at the origin, hold across a timestamp wrap
    send_sample(4'd15, 11'd0, 11'd0, 11'd2047, 32'hFFFF_FF00);
    send_sample(4'd15, 11'd5, 11'd5, 11'd2047, 32'h0000_0100);
    send_sample(4'd0, 11'd5, 11'd5, 11'd0, 32'h0000_0110);
    // slide up then down with the vertical threshold zeroed
    send_sample(4'd1, 11'd500, 11'd500, 11'd0, 32'd2000);
    send_sample(4'd1, 11'd500, 11'd400, 11'd0, 32'd2010);
    send_sample(4'd1, 11'd500, 11'd520, 11'd0, 32'd2020);
    send_sample(4'd0, 11'd500, 11'd520, 11'd0, 32'd2030);
    // slide left then right in one press
    send_sample(4'd1, 11'd500, 11'd500, 11'd0, 32'd3000);
    send_sample(4'd1, 11'd300, 11'd500, 11'd0, 32'd3010);
    send_sample(4'd1, 11'd700, 11'd500, 11'd0, 32'd3020);
    send_sample(4'd0, 11'd700, 11'd500, 11'd0, 32'd3030);
    // two-finger slide right
    send_sample(4'd2, 11'd500, 11'd500, 11'd0, 32'd4000);
    send_sample(4'd2, 11'd700, 11'd500, 11'd800, 32'd4010);
    send_sample(4'd0, 11'd700, 11'd500, 11'd800, 32'd4020);
    // top edge zone forces slide down, bottom edge zone slide up
    send_sample(4'd1, 11'd500, 11'd10, 11'd0, 32'd5000);
    send_sample(4'd0, 11'd500, 11'd10, 11'd0, 32'd5010);
    send_sample(4'd1, 11'd500, 11'd2047, 11'd0, 32'd6000);
    send_sample(4'd0, 11'd500, 11'd2047, 11'd0, 32'd6010);
    drain();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      // pick settings: reset values, all low, all high, then random
      case (phase)
        0: settings = '{TAP_RADIUS_RST, SLIDE_VERT_RST, SLIDE_HORZ_RST,
                        HOLD_TIME_RST, TOP_EDGE_RST, BOTTOM_EDGE_RST};
        1: settings = '{0, 0, 0, 0, 0, 0};
        2: settings = '{COORD_MAX, COORD_MAX, COORD_MAX, (1 << HOLD_BITS) - 1,
                        COORD_MAX, COORD_MAX};
        default: begin
          settings[0] = $urandom_range(0, 200);
          settings[1] = $urandom_range(0, 200);
          settings[2] = $urandom_range(0, 400);
          settings[3] = $urandom_range(0, 1000);
          settings[4] = $urandom_range(0, 100);
          settings[5] = $urandom_range(900, COORD_MAX);
        end
      endcase
      reg_idx = '{REG_TAP_RADIUS, REG_SLIDE_VERT, REG_SLIDE_HORZ, REG_HOLD_TIME,
                  REG_TOP_EDGE, REG_BOTTOM_EDGE,
                  (phase % 2 == 0) ? REG_BOTTOM_EDGE + 3'd1 : REG_BOTTOM_EDGE + 3'd2};
      // settings writes, a spare index last
      for (k = 0; k < 7; k++) begin
        reg_val   = (k < 6) ? CFG_W'(settings[k]) : CFG_W'($urandom());
        cfg_we    <= 1'b1;
        cfg_idx   <= reg_idx[k];
        cfg_wdata <= reg_val;
        @(posedge clk);
      end
      cfg_we <= 1'b0;

      src_idle_en = (phase % 2 == 0);
      snk_idle_en = (phase != 1 && phase != 2);
      // back up the output while samples keep coming
      if (phase == 3) begin
        long_stall = 1'b1;
      end
      ms_now     = $urandom();
      phase_base = words_sent;

      while (words_sent - phase_base < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise word
          send_sample(4'($urandom_range(0, 15)), CW'($urandom_range(0, COORD_MAX)),
                      CW'($urandom_range(0, COORD_MAX)), CW'($urandom_range(0, COORD_MAX)),
                      $urandom());
        end else begin
          // press, a few moves, release
          case ($urandom_range(0, 9))
            0, 1:    cnt = 4'd2;
            2:       cnt = 4'($urandom_range(3, 15));
            default: cnt = 4'd1;
          endcase
          // mostly press near the previous spot so taps pair up
          if ($urandom_range(0, 2) == 0) begin
            base_x = $urandom_range(0, COORD_MAX);
            base_y = $urandom_range(0, COORD_MAX);
          end
          span = settings[0] + 1;
          px   = clip(base_x + int'($urandom_range(0, 2 * span)) - span);
          py   = clip(base_y + int'($urandom_range(0, 2 * span)) - span);
          t0   = ms_now;
          send_sample(cnt, CW'(px), CW'(py), clip(px + int'($urandom_range(0, 80)) - 40),
                      ms_now);
          moves = $urandom_range(0, 4);
          for (k = 0; k < moves; k++) begin
            case ($urandom_range(0, 2))
              0:       span = settings[0] + 1;
              1:       span = 2 * ((settings[1] > settings[2]) ? settings[1] : settings[2]) + 2;
              default: span = COORD_MAX;
            endcase
            // elapsed time right at the hold boundary, around it, or short
            case ($urandom_range(0, 3))
              0:       ms_now = t0 + settings[3] + $urandom_range(0, 1);
              1:       ms_now = ms_now + $urandom_range(0, 2 * settings[3] + 2);
              default: ms_now = ms_now + $urandom_range(0, 30);
            endcase
            px = clip(px + int'($urandom_range(0, 2 * span)) - span);
            py = clip(py + int'($urandom_range(0, 2 * span)) - span);
            send_sample(cnt, CW'(px), CW'(py),
                        clip(px + int'($urandom_range(0, 2 * span)) - span / 2), ms_now);
          end
          ms_now = ms_now + $urandom_range(0, 30);
          send_sample(4'd0, CW'($urandom_range(0, COORD_MAX)), CW'($urandom_range(0, COORD_MAX)),
                      CW'($urandom_range(0, COORD_MAX)), ms_now);
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
